// ===== rtl/core/bsrs_pkg.sv =====
// ----------------------------------------------------------------------------
// bsrs_pkg
// Shared types and constants for the bounded set with rank select.
// ----------------------------------------------------------------------------
package bsrs_pkg;

    localparam int OP_W        = 2;
    localparam int KEY_IN_W    = 32;
    localparam int RANK_W      = 8;
    localparam int COUNT_OUT_W = 9;
    localparam int S_TDATA_W   = 48;
    localparam int M_TDATA_W   = 48;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT   = 2'd0,
        OP_ERASE    = 2'd1,
        OP_CONTAINS = 2'd2,
        OP_GET      = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        CMD_HOLD   = 2'd0,
        CMD_EVAL   = 2'd1,
        CMD_INSERT = 2'd2,
        CMD_ERASE  = 2'd3
    } cell_cmd_t;

    typedef struct packed {
        logic eq;   // holds the request key
        logic pos;  // empty or holds a larger key: shifts up on insert
        logic ge;   // holds a key not below the request: shifts down on erase
        logic sel;  // holds the key at the requested rank
    } cell_flags_t;

endpackage

// ===== rtl/core/bsrs_cell.sv =====
// ----------------------------------------------------------------------------
// bsrs_cell
// One slot of the sorted key chain: compares against the request, then
// keeps its key, takes the new key, or takes a neighbor's key.
// ----------------------------------------------------------------------------
module bsrs_cell #(
    parameter int KEY_WIDTH = 32,
    parameter int IDX       = 0
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  bsrs_pkg::cell_cmd_t          cmd,
    input  logic [KEY_WIDTH-1:0]         req_key,
    input  logic [bsrs_pkg::RANK_W-1:0]  req_rank,
    input  logic [KEY_WIDTH-1:0]         left_key,
    input  logic                         left_valid,
    input  logic                         left_pos,
    input  logic [KEY_WIDTH-1:0]         right_key,
    input  logic                         right_valid,
    output logic [KEY_WIDTH-1:0]         key,
    output logic                         valid,
    output bsrs_pkg::cell_flags_t        flags
);
    import bsrs_pkg::*;

    logic [KEY_WIDTH-1:0] key_reg, key_next;
    logic                 valid_reg, valid_next;
    cell_flags_t          flags_reg, flags_next;
    logic                 rank_hit;

    assign rank_hit = (IDX < (1 << RANK_W)) && (req_rank == IDX[RANK_W-1:0]);

    always_comb
    begin
        key_next   = key_reg;
        valid_next = valid_reg;
        flags_next = flags_reg;
        case (cmd)
            CMD_EVAL:
            begin
                flags_next.eq  = valid_reg && (key_reg == req_key);
                flags_next.pos = !valid_reg || (key_reg > req_key);
                flags_next.ge  = valid_reg && (key_reg >= req_key);
                flags_next.sel = valid_reg && rank_hit;
            end
            CMD_INSERT:
            begin
                if (flags_reg.pos)
                begin
                    if (!left_pos)
                    begin
                        key_next   = req_key;
                        valid_next = 1'b1;
                    end
                    else
                    begin
                        key_next   = left_key;
                        valid_next = left_valid;
                    end
                end
            end
            CMD_ERASE:
            begin
                if (flags_reg.ge)
                begin
                    key_next   = right_key;
                    valid_next = right_valid;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            flags_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            flags_reg <= flags_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    assign key   = key_reg;
    assign valid = valid_reg;
    assign flags = flags_reg;

endmodule

// ===== rtl/core/bounded_set_with_rank_select.sv =====
// ----------------------------------------------------------------------------
// bounded_set_with_rank_select
// Set of distinct keys kept sorted in a chain of cells, with rank lookup.
// ----------------------------------------------------------------------------
// Usage:
//   Request words enter on the s_axis channel, one result word per request
//   leaves on the m_axis channel. Requests: insert, erase, contains, get.
//   Keys are held in ascending order, one per cell; an insert shifts the
//   larger keys up one cell, an erase shifts them down one cell.
// Request sequence:
//   A request passes the accept in ST_IDLE, a compare in ST_EVAL in which every
//   cell compares its key against the request, and an update in ST_APPLY in
//   which the cells update and the result word is registered. The next request
//   is taken in the cycle after the result is registered; no new request is
//   taken while one is in ST_EVAL or ST_APPLY.
// Reset:
//   rst_n clears the member count and every cell's valid bit; the set is
//   empty and ready right after reset. No clearing sweep is needed.
// Stall:
//   A waiting result does not stop the next request from being accepted and
//   compared; its update waits until the output register is free.
// ----------------------------------------------------------------------------
module bounded_set_with_rank_select #(
    parameter int CAPACITY  = 256,
    parameter int KEY_WIDTH = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // operation[1:0], key_in[33:2], rank_index[41:34], zero pad[47:42]
    input  logic [bsrs_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // success[0], key_out[32:1], member_count[41:33], is_empty[42], pad[47:43]
    output logic [bsrs_pkg::M_TDATA_W-1:0]    m_axis_tdata
);
    import bsrs_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_APPLY
    } state_t;

    state_t                 state_reg, state_next;
    op_t                    op_reg, op_next;
    logic [KEY_WIDTH-1:0]   key_reg, key_next;
    logic [RANK_W-1:0]      rank_reg, rank_next;
    logic [CW-1:0]          count_reg, count_next;
    logic                   out_valid_reg, out_valid_next;
    logic [M_TDATA_W-1:0]   out_data_reg, out_data_next;

    logic [KEY_WIDTH-1:0]   in_key;
    logic [KEY_IN_W-1:0]    sel_key_out;
    logic [COUNT_OUT_W-1:0] count_out;

    cell_cmd_t              cmd;
    logic [KEY_WIDTH-1:0]   cell_key   [CAPACITY];
    logic                   cell_valid [CAPACITY];
    cell_flags_t            cell_flags [CAPACITY];

    logic                   found;
    logic                   rank_ok;
    logic [KEY_WIDTH-1:0]   sel_key;
    logic                   out_free;
    logic                   s_accept;

    // key_in taken modulo 2^KEY_WIDTH, stored key zero-extended or truncated to 32 bits
    generate
        if (KEY_WIDTH < KEY_IN_W)
        begin : g_key_narrow
            assign in_key      = s_axis_tdata[OP_W +: KEY_WIDTH];
            assign sel_key_out = {{(KEY_IN_W - KEY_WIDTH){1'b0}}, sel_key};
        end
        else if (KEY_WIDTH == KEY_IN_W)
        begin : g_key_same
            assign in_key      = s_axis_tdata[OP_W +: KEY_IN_W];
            assign sel_key_out = sel_key;
        end
        else
        begin : g_key_wide
            assign in_key      = {{(KEY_WIDTH - KEY_IN_W){1'b0}},
                                  s_axis_tdata[OP_W +: KEY_IN_W]};
            assign sel_key_out = sel_key[KEY_IN_W-1:0];
        end
    endgenerate

    generate
        if (CW < COUNT_OUT_W)
        begin : g_cnt_narrow
            assign count_out = {{(COUNT_OUT_W - CW){1'b0}}, count_next};
        end
        else
        begin : g_cnt_wide
            assign count_out = count_next[COUNT_OUT_W-1:0];
        end
    endgenerate

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic [KEY_WIDTH-1:0] lk, rk;
            logic                 lv, lp, rv;
            if (gi == 0)
            begin : g_first
                assign lk = '0;
                assign lv = 1'b0;
                assign lp = 1'b0;
            end
            else
            begin : g_inner_l
                assign lk = cell_key[gi-1];
                assign lv = cell_valid[gi-1];
                assign lp = cell_flags[gi-1].pos;
            end
            if (gi == CAPACITY - 1)
            begin : g_last
                assign rk = '0;
                assign rv = 1'b0;
            end
            else
            begin : g_inner_r
                assign rk = cell_key[gi+1];
                assign rv = cell_valid[gi+1];
            end
            bsrs_cell #(
                .KEY_WIDTH (KEY_WIDTH),
                .IDX       (gi)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .cmd         (cmd),
                .req_key     (key_reg),
                .req_rank    (rank_reg),
                .left_key    (lk),
                .left_valid  (lv),
                .left_pos    (lp),
                .right_key   (rk),
                .right_valid (rv),
                .key         (cell_key[gi]),
                .valid       (cell_valid[gi]),
                .flags       (cell_flags[gi])
            );
        end
    endgenerate

    always_comb
    begin
        found   = 1'b0;
        rank_ok = 1'b0;
        sel_key = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            found   = found | cell_flags[i].eq;
            rank_ok = rank_ok | cell_flags[i].sel;
            sel_key = sel_key | (cell_key[i] & {KEY_WIDTH{cell_flags[i].sel}});
        end
    end

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        logic            ok;
        logic            is_get;
        state_next     = state_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        rank_next      = rank_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        cmd            = CMD_HOLD;
        ok             = 1'b0;
        is_get         = 1'b0;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    op_next    = op_t'(s_axis_tdata[OP_W-1:0]);
                    key_next   = in_key;
                    rank_next  = s_axis_tdata[OP_W + KEY_IN_W +: RANK_W];
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                cmd        = CMD_EVAL;
                state_next = ST_APPLY;
            end
            ST_APPLY:
            begin
                if (out_free)
                begin
                    case (op_reg)
                        OP_INSERT:
                        begin
                            ok = !found && (count_reg < CW'(CAPACITY));
                            if (ok)
                            begin
                                cmd        = CMD_INSERT;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        OP_ERASE:
                        begin
                            ok = found;
                            if (ok)
                            begin
                                cmd        = CMD_ERASE;
                                count_next = count_reg - CW'(1);
                            end
                        end
                        OP_CONTAINS:
                        begin
                            ok = found;
                        end
                        default:
                        begin
                            ok     = rank_ok;
                            is_get = 1'b1;
                        end
                    endcase
                    out_data_next = {{(M_TDATA_W - 2 - KEY_IN_W - COUNT_OUT_W){1'b0}},
                                     (count_next == '0),
                                     count_out,
                                     (ok && is_get) ? sel_key_out : '0,
                                     ok};
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        key_reg      <= key_next;
        rank_reg     <= rank_next;
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

// ===== dv/bsrs_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsrs_checker
// Watches both stream channels of the bounded set, keeps a sorted shadow of
// the stored keys, predicts one result word per accepted request and checks
// every result word against the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module bsrs_checker #(
    parameter int CAPACITY = 256
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    input  logic                           s_axis_tready,
    // operation[1:0], key_in[33:2], rank_index[41:34], zero pad[47:42]
    input  logic [bsrs_pkg::S_TDATA_W-1:0] s_axis_tdata,
    input  logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // success[0], key_out[32:1], member_count[41:33], is_empty[42], pad[47:43]
    input  logic [bsrs_pkg::M_TDATA_W-1:0] m_axis_tdata,
    output int                             mismatches,
    output int                             outstanding
);
    import bsrs_pkg::*;

    typedef struct packed {
        logic        is_empty;
        logic [8:0]  member_count;
        logic [31:0] key_out;
        logic        success;
    } set_result_t;

    logic [31:0] sorted_keys[$];
    set_result_t result_queue[$];
    set_result_t got;
    set_result_t want;
    int          err_count;

    // first position whose key is not below the given key
    function automatic int lower_bound(input logic [31:0] key);
        int pos;
        begin
            pos = 0;
            while (pos < sorted_keys.size() && sorted_keys[pos] < key)
                pos++;
            return pos;
        end
    endfunction

    function automatic set_result_t serve_request(input op_t op, input logic [31:0] key,
                                                  input logic [7:0] rank);
        set_result_t r;
        int          pos;
        bit          hit;
        begin
            r   = '0;
            pos = lower_bound(key);
            hit = (pos < sorted_keys.size()) && (sorted_keys[pos] == key);
            case (op)
                OP_INSERT:
                    if (!hit && sorted_keys.size() < CAPACITY)
                    begin
                        sorted_keys.insert(pos, key);
                        r.success = 1'b1;
                    end
                OP_ERASE:
                    if (hit)
                    begin
                        sorted_keys.delete(pos);
                        r.success = 1'b1;
                    end
                OP_CONTAINS:
                    r.success = hit;
                default:
                    if (int'(rank) < sorted_keys.size())
                    begin
                        r.key_out = sorted_keys[rank];
                        r.success = 1'b1;
                    end
            endcase
            r.member_count = 9'(sorted_keys.size());
            r.is_empty     = (sorted_keys.size() == 0);
            return r;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sorted_keys.delete();
            result_queue.delete();
            err_count   = 0;
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = set_result_t'(m_axis_tdata[42:0]);
                if (result_queue.size() == 0)
                begin
                    $error("result word with no request outstanding: %h", m_axis_tdata);
                    err_count++;
                end
                else
                begin
                    want = result_queue.pop_front();
                    if (got.success !== want.success)
                    begin
                        $error("success: expected %0d, actual %0d", want.success, got.success);
                        err_count++;
                    end
                    if (got.key_out !== want.key_out)
                    begin
                        $error("key_out: expected %h, actual %h", want.key_out, got.key_out);
                        err_count++;
                    end
                    if (got.member_count !== want.member_count)
                    begin
                        $error("member_count: expected %0d, actual %0d",
                               want.member_count, got.member_count);
                        err_count++;
                    end
                    if (got.is_empty !== want.is_empty)
                    begin
                        $error("is_empty: expected %0d, actual %0d", want.is_empty, got.is_empty);
                        err_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                result_queue.push_back(serve_request(op_t'(s_axis_tdata[1:0]),
                                                     s_axis_tdata[33:2],
                                                     s_axis_tdata[41:34]));
            mismatches  <= err_count;
            outstanding <= result_queue.size();
        end
    end

endmodule

// ===== dv/tb_bounded_set_with_rank_select.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bounded_set_with_rank_select
// Drives request words into the bounded set: directed edge keys and ranks,
// then random mixes over a small key pool, a fill to capacity with refused
// inserts, and a partial drain. Both sides idle at random; a long output
// stall backs the block up. The checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_bounded_set_with_rank_select;
    import bsrs_pkg::*;

    localparam int IDLE_PCT       = 33;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int POOL_SIZE      = 16;
    localparam int MIX_WORDS      = 160;
    localparam int FILL_WORDS     = 280;
    localparam int FULL_WORDS     = 40;
    localparam int SHRINK_WORDS   = 170;

    logic                 clk;
    logic                 rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    // operation[1:0], key_in[33:2], rank_index[41:34], zero pad[47:42]
    logic [S_TDATA_W-1:0] s_axis_tdata;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    // success[0], key_out[32:1], member_count[41:33], is_empty[42], pad[47:43]
    logic [M_TDATA_W-1:0] m_axis_tdata;

    int          mismatches;
    int          outstanding;
    bit          no_idle;
    bit          hold_req;
    int          op_sent[4];
    logic [31:0] key_pool[POOL_SIZE];
    logic [31:0] fill_keys[FILL_WORDS];

    bounded_set_with_rank_select #(
        .CAPACITY  (256),
        .KEY_WIDTH (32)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    bsrs_checker #(
        .CAPACITY (256)
    ) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // result side: random stalls, one long hold-off on request
    initial
    begin
        bit hold_done;
        hold_done     = 1'b0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            m_axis_tready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    task automatic send_word(input op_t op, input logic [31:0] key, input logic [7:0] rank);
        begin
            while (!no_idle && $urandom_range(0, 99) < IDLE_PCT)
            begin
                s_axis_tvalid <= 1'b0;
                @(posedge clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= {{(S_TDATA_W - 42){1'b0}}, rank, key, op};
            op_sent[op]++;
            do @(posedge clk); while (!s_axis_tready);
        end
    endtask

    task automatic wait_all_results();
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
            while (outstanding != 0) @(posedge clk);
        end
    endtask

    function automatic op_t pick_op();
        int roll;
        begin
            roll = $urandom_range(0, 99);
            if (roll < 35)
                return OP_INSERT;
            else if (roll < 60)
                return OP_ERASE;
            else if (roll < 80)
                return OP_CONTAINS;
            return OP_GET;
        end
    endfunction

    function automatic logic [31:0] pick_key();
        begin
            if ($urandom_range(0, 99) < 90)
                return key_pool[$urandom_range(0, POOL_SIZE - 1)];
            return $urandom;
        end
    endfunction

    function automatic logic [7:0] pick_rank();
        begin
            if ($urandom_range(0, 99) < 80)
                return 8'($urandom_range(0, 20));
            return 8'($urandom);
        end
    endfunction

    initial
    begin
        int i;
        int cursor;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        no_idle       = 1'b0;
        hold_req      = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty set, edge keys, duplicate, rank out of range
        send_word(OP_GET,      32'h0000_0000, 8'd0);
        send_word(OP_ERASE,    32'h0000_0000, 8'd0);
        send_word(OP_CONTAINS, 32'hFFFF_FFFF, 8'hFF);
        send_word(OP_INSERT,   32'h0000_0000, 8'd0);
        send_word(OP_INSERT,   32'hFFFF_FFFF, 8'hFF);
        send_word(OP_INSERT,   32'h0000_0000, 8'd0);
        send_word(OP_INSERT,   32'h8000_0000, 8'h80);
        send_word(OP_INSERT,   32'h7FFF_FFFF, 8'h7F);
        send_word(OP_CONTAINS, 32'h0000_0000, 8'd0);
        send_word(OP_CONTAINS, 32'hFFFF_FFFF, 8'd0);
        send_word(OP_CONTAINS, 32'h1234_5678, 8'd0);
        send_word(OP_GET,      32'hFFFF_FFFF, 8'd0);
        send_word(OP_GET,      32'h0000_0000, 8'd3);
        send_word(OP_GET,      32'h0000_0000, 8'd4);
        send_word(OP_GET,      32'hFFFF_FFFF, 8'hFF);
        send_word(OP_ERASE,    32'h8000_0000, 8'd0);
        send_word(OP_ERASE,    32'h8000_0000, 8'd0);
        send_word(OP_GET,      32'h0000_0000, 8'd1);
        send_word(OP_ERASE,    32'h0000_0000, 8'd0);
        send_word(OP_ERASE,    32'hFFFF_FFFF, 8'd0);
        send_word(OP_ERASE,    32'h7FFF_FFFF, 8'd0);
        send_word(OP_GET,      32'h0000_0000, 8'd0);
        wait_all_results();

        for (i = 0; i < POOL_SIZE; i++)
            key_pool[i] = $urandom;
        for (i = 0; i < MIX_WORDS; i++)
        begin
            no_idle = (i >= MIX_WORDS / 2);
            send_word(pick_op(), pick_key(), pick_rank());
        end
        no_idle = 1'b0;

        // distinct keys by construction so the store must reach capacity
        hold_req = 1'b1;
        for (i = 0; i < FILL_WORDS; i++)
        begin
            fill_keys[i] = {9'(i), 23'($urandom)};
            send_word(OP_INSERT, fill_keys[i], 8'($urandom));
        end

        send_word(OP_GET, $urandom, 8'hFF);
        for (i = 0; i < FULL_WORDS; i++)
        begin
            case ($urandom_range(0, 2))
                0:       send_word(OP_INSERT, $urandom, 8'($urandom));
                1:       send_word(OP_GET, $urandom, 8'($urandom));
                default: send_word(OP_CONTAINS, fill_keys[$urandom_range(0, FILL_WORDS - 1)],
                                   8'($urandom));
            endcase
        end
        wait_all_results();

        cursor = $urandom_range(0, FILL_WORDS - 1);
        for (i = 0; i < SHRINK_WORDS; i++)
        begin
            if ($urandom_range(0, 99) < 70)
            begin
                send_word(OP_ERASE, fill_keys[cursor], 8'($urandom));
                cursor = (cursor + 97) % FILL_WORDS;
            end
            else
                send_word(pick_op(), pick_key(), 8'($urandom));
        end

        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d requests: insert %0d, erase %0d, contains %0d, get %0d.",
                 op_sent[0] + op_sent[1] + op_sent[2] + op_sent[3],
                 op_sent[OP_INSERT], op_sent[OP_ERASE], op_sent[OP_CONTAINS], op_sent[OP_GET]);
        $display("Edge keys and ranks, pool mixes, a fill to capacity under a long stall, a drain.");
        if (mismatches == 0 && outstanding == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/bsrs_pkg.sv
rtl/core/bsrs_cell.sv
rtl/core/bounded_set_with_rank_select.sv
dv/bsrs_checker.sv
dv/tb_bounded_set_with_rank_select.sv
